// ----- hw/rtl/fcnat_pkg.sv -----
package fcnat_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam logic [1:0] ACT_OUT = 2'd0;
    localparam logic [1:0] ACT_IN  = 2'd1;
    localparam logic [1:0] ACT_RM  = 2'd2;
    localparam logic [1:0] ACT_UNK = 2'd3;

    localparam logic [2:0] ST_REUSED   = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_DROP     = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_PASS     = 3'd5;

    localparam logic [1:0] REG_PORT_MIN  = 2'd0;
    localparam logic [1:0] REG_PRES_LOW  = 2'd1;
    localparam logic [1:0] REG_PRES_HIGH = 2'd2;
    localparam logic [1:0] REG_RETRIES   = 2'd3;

    localparam logic [15:0] PORT_MIN_RST  = 16'd20000;
    localparam logic [15:0] PRES_LOW_RST  = 16'd1024;
    localparam logic [15:0] PRES_HIGH_RST = 16'd65534;
    localparam logic [5:0]  RETRIES_RST   = 6'd20;
    localparam logic [15:0] LFSR_RST      = 16'hACE1;

    // lookup key broadcast to every cell
    typedef struct packed {
        logic [31:0] iaddr;
        logic [15:0] iport;
        logic [31:0] eaddr;
        logic [15:0] eport;
    } qry_t;

    // search token passed from cell to cell, keeps the first hit of each kind
    typedef struct packed {
        logic             vld;
        logic             hit_out;
        logic [15:0]      out_port;
        logic             hit_in;
        logic [31:0]      in_addr;
        logic [15:0]      in_port;
        logic             hit_rm;
        logic [IDX_W-1:0] rm_idx;
        logic             has_free;
        logic [IDX_W-1:0] free_idx;
    } tok_t;

    typedef struct packed {
        logic             set;
        logic             clr;
        logic [IDX_W-1:0] idx;
        logic [31:0]      iaddr;
        logic [15:0]      iport;
        logic [31:0]      eaddr;
        logic [15:0]      eport;
    } wr_t;

    function automatic logic [15:0] lfsr_adv(input logic [15:0] s);
        logic fb;
        fb = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {fb, s[15:1]};
    endfunction

endpackage

// ----- hw/rtl/fcnat_if.sv -----
interface fcnat_in_if;
    import fcnat_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic        is_udp;
    logic [31:0] lan_addr;
    logic [15:0] lan_port;
    logic [31:0] ext_addr;
    logic [15:0] wan_port;
    modport source (output valid, action, is_udp, lan_addr, lan_port, ext_addr, wan_port,
                    input ready);
    modport sink (input valid, action, is_udp, lan_addr, lan_port, ext_addr, wan_port,
                  output ready);
endinterface

interface fcnat_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    modport source (output valid, status, out_addr, out_port, input ready);
    modport sink (input valid, status, out_addr, out_port, output ready);
endinterface

// ----- hw/rtl/fcnat_cell.sv -----
module fcnat_cell
    import fcnat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  qry_t             qry,
    input  wr_t              wr,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic        valid_reg;
    logic [31:0] iaddr_reg;
    logic [15:0] iport_reg;
    logic [31:0] eaddr_reg;
    logic [15:0] eport_reg;
    tok_t        tok_reg;
    tok_t        tok_next;
    logic        m_out;
    logic        m_in;
    logic        m_rm;
    logic        sel;

    assign sel   = (wr.idx == cell_idx);
    assign m_out = valid_reg && iaddr_reg == qry.iaddr && iport_reg == qry.iport
                   && eaddr_reg == qry.eaddr;
    assign m_in  = valid_reg && eaddr_reg == qry.eaddr && eport_reg == qry.eport;
    assign m_rm  = m_out && eport_reg == qry.eport;

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit_out && m_out)
        begin
            tok_next.hit_out  = 1'b1;
            tok_next.out_port = eport_reg;
        end
        if (!tok_in.hit_in && m_in)
        begin
            tok_next.hit_in  = 1'b1;
            tok_next.in_addr = iaddr_reg;
            tok_next.in_port = iport_reg;
        end
        if (!tok_in.hit_rm && m_rm)
        begin
            tok_next.hit_rm = 1'b1;
            tok_next.rm_idx = cell_idx;
        end
        if (!tok_in.has_free && !valid_reg)
        begin
            tok_next.has_free = 1'b1;
            tok_next.free_idx = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (sel && wr.set)
                valid_reg <= 1'b1;
            else if (sel && wr.clr)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && wr.set)
        begin
            iaddr_reg <= wr.iaddr;
            iport_reg <= wr.iport;
            eaddr_reg <= wr.eaddr;
            eport_reg <= wr.eport;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- hw/rtl/fcnat_mod.sv -----
module fcnat_mod
    import fcnat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [15:0] rem
);

    logic        busy_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] dvd_reg;
    logic [15:0] rem_reg;
    logic [16:0] dsr_reg;
    logic [16:0] trial;
    logic [16:0] diff;

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, dvd_reg[15]};
    assign diff  = trial - dsr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[14:0], 1'b0};
            rem_reg <= (trial >= dsr_reg) ? diff[15:0] : trial[15:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- hw/rtl/fullcone_nat_mapping_table.sv -----
// pass and unknown actions go straight to the result; lookups sweep the ENTRIES cells
// a new port candidate adds a modulo run in the divider and another sweep of the table
// throughput: one item at a time; a new item is taken only back in the idle state
// reset: all entries invalid, lfsr 0xACE1, registers at their defaults; no clearing pass
module fullcone_nat_mapping_table
    import fcnat_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    fcnat_in_if.sink    in_ch,
    fcnat_out_if.source out_ch
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOOK  = 5'b00010,
        S_CAND  = 5'b00100,
        S_CHECK = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    qry_t             q_reg, q_next;
    logic [1:0]       act_reg, act_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [5:0]       try_reg, try_next;
    logic [15:0]      lfsr_reg, lfsr_next;
    logic [2:0]       st_reg, st_next;
    logic [31:0]      oaddr_reg, oaddr_next;
    logic [15:0]      oport_reg, oport_next;
    logic [15:0]      port_min_reg;
    logic [15:0]      pres_low_reg;
    logic [15:0]      pres_high_reg;
    logic [5:0]       retries_reg;
    logic             go_reg;

    tok_t             tok [0:ENTRIES];
    tok_t             tok_end;
    wr_t              wr;
    logic             tok_start;
    logic             mod_start;
    logic             mod_done;
    logic [15:0]      mod_rem;
    logic             cfg_wr;
    logic             keep_ok;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_min_reg  <= PORT_MIN_RST;
            pres_low_reg  <= PRES_LOW_RST;
            pres_high_reg <= PRES_HIGH_RST;
            retries_reg   <= RETRIES_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PORT_MIN:  port_min_reg  <= pwdata[15:0];
                REG_PRES_LOW:  pres_low_reg  <= pwdata[15:0];
                REG_PRES_HIGH: pres_high_reg <= pwdata[15:0];
                REG_RETRIES:   retries_reg   <= pwdata[5:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PORT_MIN:  prdata = {16'd0, port_min_reg};
            REG_PRES_LOW:  prdata = {16'd0, pres_low_reg};
            REG_PRES_HIGH: prdata = {16'd0, pres_high_reg};
            REG_RETRIES:   prdata = {26'd0, retries_reg};
            default:       prdata = '0;
        endcase
    end

    // row of cells; the token leaves once the query register holds the new key
    always_comb
    begin
        tok[0]     = '0;
        tok[0].vld = go_reg;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        fcnat_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(i)),
            .qry      (q_reg),
            .wr       (wr),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1])
        );
    end

    assign tok_end = tok[ENTRIES];

    fcnat_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (lfsr_next),
        .divisor  (17'h10000 - {1'b0, port_min_reg}),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    assign keep_ok = q_reg.iport != 16'd0 && q_reg.iport >= pres_low_reg
                     && q_reg.iport <= pres_high_reg && !tok_end.hit_in;

    always_comb
    begin
        state_next = state_reg;
        q_next     = q_reg;
        act_next   = act_reg;
        slot_next  = slot_reg;
        try_next   = try_reg;
        lfsr_next  = lfsr_reg;
        st_next    = st_reg;
        oaddr_next = oaddr_reg;
        oport_next = oport_reg;
        tok_start  = 1'b0;
        mod_start  = 1'b0;
        wr         = '0;
        wr.idx     = slot_reg;
        wr.iaddr   = q_reg.iaddr;
        wr.iport   = q_reg.iport;
        wr.eaddr   = q_reg.eaddr;
        wr.eport   = q_reg.eport;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    act_next     = in_ch.action;
                    q_next.iaddr = in_ch.lan_addr;
                    q_next.iport = in_ch.lan_port;
                    q_next.eaddr = in_ch.ext_addr;
                    // outbound sweeps also check whether the internal port is taken
                    q_next.eport = (in_ch.action == ACT_OUT) ? in_ch.lan_port
                                                             : in_ch.wan_port;
                    try_next     = '0;
                    st_next      = ST_PASS;
                    oaddr_next   = in_ch.ext_addr;
                    oport_next   = (in_ch.action == ACT_OUT) ? in_ch.lan_port
                                                             : in_ch.wan_port;
                    if (in_ch.action != ACT_OUT && in_ch.action != ACT_IN
                        && in_ch.action != ACT_RM)
                    begin
                        oaddr_next = '0;
                        oport_next = '0;
                        state_next = S_OUT;
                    end
                    else if (!in_ch.is_udp && in_ch.action != ACT_RM)
                        state_next = S_OUT;
                    else
                    begin
                        tok_start  = 1'b1;
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK:
            begin
                if (tok_end.vld)
                begin
                    state_next = S_OUT;
                    oaddr_next = '0;
                    oport_next = '0;
                    if (act_reg == ACT_IN)
                    begin
                        if (tok_end.hit_in)
                        begin
                            st_next    = ST_REUSED;
                            oaddr_next = tok_end.in_addr;
                            oport_next = tok_end.in_port;
                        end
                        else
                            st_next = ST_NOTFOUND;
                    end
                    else if (act_reg == ACT_RM)
                    begin
                        if (tok_end.hit_rm)
                        begin
                            wr.clr  = 1'b1;
                            wr.idx  = tok_end.rm_idx;
                            st_next = ST_REMOVED;
                        end
                        else
                            st_next = ST_NOTFOUND;
                    end
                    else if (tok_end.hit_out)
                    begin
                        st_next    = ST_REUSED;
                        oaddr_next = q_reg.eaddr;
                        oport_next = tok_end.out_port;
                    end
                    else if (!tok_end.has_free)
                        st_next = ST_DROP;
                    else if (keep_ok)
                    begin
                        wr.set     = 1'b1;
                        wr.idx     = tok_end.free_idx;
                        st_next    = ST_NEW;
                        oaddr_next = q_reg.eaddr;
                        oport_next = q_reg.iport;
                    end
                    else if (retries_reg == 6'd0)
                        st_next = ST_DROP;
                    else
                    begin
                        slot_next  = tok_end.free_idx;
                        lfsr_next  = lfsr_adv(lfsr_reg);
                        mod_start  = 1'b1;
                        state_next = S_CAND;
                    end
                end
            end
            S_CAND:
            begin
                if (mod_done)
                begin
                    q_next.eport = port_min_reg + mod_rem;
                    try_next     = try_reg + 6'd1;
                    tok_start    = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (tok_end.vld)
                begin
                    oaddr_next = '0;
                    oport_next = '0;
                    if (!tok_end.hit_in)
                    begin
                        wr.set     = 1'b1;
                        st_next    = ST_NEW;
                        oaddr_next = q_reg.eaddr;
                        oport_next = q_reg.eport;
                        state_next = S_OUT;
                    end
                    else if (try_reg == retries_reg)
                    begin
                        st_next    = ST_DROP;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        lfsr_next  = lfsr_adv(lfsr_reg);
                        mod_start  = 1'b1;
                        state_next = S_CAND;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lfsr_reg  <= LFSR_RST;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            lfsr_reg  <= lfsr_next;
            go_reg    <= tok_start;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg     <= q_next;
        act_reg   <= act_next;
        slot_reg  <= slot_next;
        try_reg   <= try_next;
        st_reg    <= st_next;
        oaddr_reg <= oaddr_next;
        oport_reg <= oport_next;
    end

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = (state_reg == S_OUT);
    assign out_ch.status   = st_reg;
    assign out_ch.out_addr = oaddr_reg;
    assign out_ch.out_port = oport_reg;

endmodule

// ----- hw/rtl/fcnat_checker.sv -----
module fcnat_checker
    import fcnat_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] out_addr,
    input logic [15:0] out_port
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    // one item in flight at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input open while result pending");

    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DROP || status == ST_NOTFOUND || status == ST_REMOVED)
        |-> out_addr == 32'd0 && out_port == 16'd0)
        else $error("nonzero translation on miss");

endmodule

bind fullcone_nat_mapping_table fcnat_checker u_fcnat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .out_addr  (out_ch.out_addr),
    .out_port  (out_ch.out_port)
);
